@@ src/disparity_row_view_warp_macros.svh @@
// Assertion macros used by the view warp RTL.
`ifndef DISPARITY_ROW_VIEW_WARP_MACROS_SVH
`define DISPARITY_ROW_VIEW_WARP_MACROS_SVH

// Implication checked on the same edge, disabled while in reset.
`define DRVW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drvw assertion failed");

// Implication checked on the next edge, disabled while in reset.
`define DRVW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drvw assertion failed");

`endif

@@ src/drvw_pkg.sv @@
// Shared types, widths and constants of the disparity row view warp.
package drvw_pkg;

    localparam int COL_W       = 11;
    localparam int CH_W        = 8;
    localparam int DISP_W      = 8;
    localparam int DIV_W       = 8;
    localparam int ROW_W       = 12;
    localparam int SRC_W       = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int PIX_W       = 3 * CH_W;
    localparam int ENTRY_W     = PIX_W + 1;
    localparam int STEP_CNT_W  = $clog2(DISP_W);

    // Line store depth; must be a power of two.
    localparam int MAX_WIDTH_DEF = 2048;

    localparam logic [DIV_W-1:0] DIVISOR_RST   = DIV_W'(10);
    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = ROW_W'(640);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_PROC = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVISOR   = 1'b0,
        CFG_ROW_WIDTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SRC,
        S_RD,
        S_WB
    } t_state;

endpackage

@@ src/drvw_item_if.sv @@
// Input channel: load or process transaction with its payload.
interface drvw_item_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [drvw_pkg::COL_W-1:0]    column;
    logic [drvw_pkg::CH_W-1:0]     red;
    logic [drvw_pkg::CH_W-1:0]     green;
    logic [drvw_pkg::CH_W-1:0]     blue;
    logic [drvw_pkg::DISP_W-1:0]   disparity;

    modport source (output valid, mode, column, red, green, blue, disparity, input ready);
    modport sink   (input valid, mode, column, red, green, blue, disparity, output ready);
endinterface

@@ src/drvw_result_if.sv @@
// Output channel: one warped pixel per process transaction.
interface drvw_result_if;
    logic                          valid;
    logic                          ready;
    logic [drvw_pkg::COL_W-1:0]    out_column;
    logic [drvw_pkg::CH_W-1:0]     out_red;
    logic [drvw_pkg::CH_W-1:0]     out_green;
    logic [drvw_pkg::CH_W-1:0]     out_blue;
    logic                          shifted;

    modport source (output valid, out_column, out_red, out_green, out_blue, shifted,
                    input ready);
    modport sink   (input valid, out_column, out_red, out_green, out_blue, shifted,
                    output ready);
endinterface

@@ src/disparity_row_view_warp.sv @@
// Load transaction: writes the line store and clears the taken mark.
// Process transaction: the 8-step restoring divider, then source address, store
// read and read-modify-write; the next transaction is taken after the write-back.
// Results wait in an output register, so the next transaction can be taken.
// Synchronous reset starts a clearing pass over all MAX_WIDTH store entries;
// no transaction is accepted during it, configuration writes still are.
`include "disparity_row_view_warp_macros.svh"

module disparity_row_view_warp #(
    parameter int MAX_WIDTH = drvw_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [drvw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [drvw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    drvw_item_if.sink                         i_item,
    drvw_result_if.source                     o_result
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Configuration
    logic [drvw_pkg::DIV_W-1:0]   r_divisor;
    logic [drvw_pkg::ROW_W-1:0]   r_row_width;
    logic [drvw_pkg::DIV_W-1:0]   w_div;

    // Control
    drvw_pkg::t_state             r_state, n_state;
    logic [AW-1:0]                r_clr_cnt, n_clr_cnt;
    logic [drvw_pkg::STEP_CNT_W-1:0] r_step, n_step;

    // Item in flight
    logic [drvw_pkg::COL_W-1:0]   r_col, n_col;
    logic [drvw_pkg::DISP_W-1:0]  r_quo, n_quo;
    logic [drvw_pkg::DIV_W-1:0]   r_rem, n_rem;
    logic [AW-1:0]                r_rd_addr, n_rd_addr;
    logic                         r_inside, n_inside;

    // Divider step
    logic [drvw_pkg::DIV_W:0]     w_trial;
    logic [drvw_pkg::SRC_W-1:0]   w_src;
    logic                         w_src_in;

    // Line store: {taken, red, green, blue}
    logic [drvw_pkg::ENTRY_W-1:0] r_mem [MAX_WIDTH];
    logic [drvw_pkg::ENTRY_W-1:0] r_rd_data;
    logic                         w_mem_we;
    logic [AW-1:0]                w_mem_waddr;
    logic [drvw_pkg::ENTRY_W-1:0] w_mem_wdata;
    logic                         w_mem_re;

    // Output register
    logic                         r_out_valid, n_out_valid;
    logic [drvw_pkg::COL_W-1:0]   r_out_col, n_out_col;
    logic [drvw_pkg::PIX_W-1:0]   r_out_pix, n_out_pix;
    logic                         r_out_shift, n_out_shift;
    logic                         w_out_load;
    logic                         w_in_acc;

    assign w_div      = (r_divisor == '0) ? drvw_pkg::DIV_W'(1) : r_divisor;
    assign w_trial    = {r_rem, r_quo[drvw_pkg::DISP_W-1]};
    assign w_src      = drvw_pkg::SRC_W'(r_quo) + drvw_pkg::SRC_W'(r_col)
                        + drvw_pkg::SRC_W'(1);
    assign w_src_in   = (w_src < r_row_width) && (32'(w_src) < MAX_WIDTH);
    assign w_out_load = !r_out_valid || o_result.ready;
    assign w_in_acc   = i_item.valid && i_item.ready;

    assign i_item.ready        = (r_state == drvw_pkg::S_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.out_column = r_out_col;
    assign o_result.out_red    = r_out_pix[3*drvw_pkg::CH_W-1:2*drvw_pkg::CH_W];
    assign o_result.out_green  = r_out_pix[2*drvw_pkg::CH_W-1:drvw_pkg::CH_W];
    assign o_result.out_blue   = r_out_pix[drvw_pkg::CH_W-1:0];
    assign o_result.shifted    = r_out_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor   <= drvw_pkg::DIVISOR_RST;
            r_row_width <= drvw_pkg::ROW_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                drvw_pkg::CFG_DIVISOR:   r_divisor   <= i_cfg_data[drvw_pkg::DIV_W-1:0];
                drvw_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_data[drvw_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drvw_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_rd_addr   <= n_rd_addr;
        r_inside    <= n_inside;
        r_out_col   <= n_out_col;
        r_out_pix   <= n_out_pix;
        r_out_shift <= n_out_shift;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_step      = r_step;
        n_col       = r_col;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_rd_addr   = r_rd_addr;
        n_inside    = r_inside;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_col   = r_out_col;
        n_out_pix   = r_out_pix;
        n_out_shift = r_out_shift;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_rd_addr;
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;

        case (r_state)
            drvw_pkg::S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_cnt;
                n_clr_cnt   = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(MAX_WIDTH - 1)) begin
                    n_state = drvw_pkg::S_IDLE;
                end
            end
            drvw_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_item.mode == drvw_pkg::MODE_LOAD) begin
                        w_mem_we    = 1'b1;
                        w_mem_waddr = AW'(i_item.column);
                        w_mem_wdata = {1'b0, i_item.red, i_item.green, i_item.blue};
                    end else begin
                        n_col   = i_item.column;
                        n_quo   = i_item.disparity;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = drvw_pkg::S_DIV;
                    end
                end
            end
            drvw_pkg::S_DIV: begin
                // One restoring step: shift in the next dividend bit, subtract if it fits.
                if (w_trial >= {1'b0, w_div}) begin
                    n_rem = drvw_pkg::DIV_W'(w_trial - {1'b0, w_div});
                    n_quo = {r_quo[drvw_pkg::DISP_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[drvw_pkg::DIV_W-1:0];
                    n_quo = {r_quo[drvw_pkg::DISP_W-2:0], 1'b0};
                end
                n_step = r_step + drvw_pkg::STEP_CNT_W'(1);
                if (r_step == drvw_pkg::STEP_CNT_W'(drvw_pkg::DISP_W - 1)) begin
                    n_state = drvw_pkg::S_SRC;
                end
            end
            drvw_pkg::S_SRC: begin
                n_inside  = w_src_in;
                n_rd_addr = w_src_in ? AW'(w_src) : AW'(r_col);
                n_state   = drvw_pkg::S_RD;
            end
            drvw_pkg::S_RD: begin
                w_mem_re = 1'b1;
                n_state  = drvw_pkg::S_WB;
            end
            drvw_pkg::S_WB: begin
                // Hold the read data until the output register frees up.
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_col;
                    n_out_shift = r_inside;
                    if (r_inside && r_rd_data[drvw_pkg::PIX_W]) begin
                        n_out_pix = '0;
                    end else begin
                        n_out_pix = r_rd_data[drvw_pkg::PIX_W-1:0];
                    end
                    if (r_inside) begin
                        w_mem_we    = 1'b1;
                        w_mem_waddr = r_rd_addr;
                        w_mem_wdata = {1'b1, r_rd_data[drvw_pkg::PIX_W-1:0]};
                    end
                    n_state = drvw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = drvw_pkg::S_IDLE;
            end
        endcase
    end

    `DRVW_ASSERT_IMP(a_clear_blocks_items, i_clk, i_rst_n,
        r_state == drvw_pkg::S_CLEAR, w_mem_we && !i_item.ready)
    `DRVW_ASSERT_IMP(a_div_rem_below_divisor, i_clk, i_rst_n,
        r_state == drvw_pkg::S_SRC, r_rem < w_div)
    `DRVW_ASSERT_NEXT(a_result_from_writeback, i_clk, i_rst_n,
        !r_out_valid && r_state != drvw_pkg::S_WB, !r_out_valid)
    `DRVW_ASSERT_IMP(a_shift_marks_taken, i_clk, i_rst_n,
        r_state == drvw_pkg::S_WB && w_out_load && r_inside,
        w_mem_we && w_mem_wdata[drvw_pkg::PIX_W] && w_mem_waddr == r_rd_addr)

endmodule

@@ tb/sv/drvw_warp_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the view warp: predicts every warped pixel and checks the result stream.
module drvw_warp_checker #(
    parameter int STORE_DEPTH = drvw_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [drvw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [drvw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    drvw_item_if                            item_ch,
    drvw_result_if                          res_ch,
    output int                              o_pending,
    output int                              o_fail_count,
    output int                              o_shifted_count
);
    import drvw_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             shifted;
    } t_warped_px;

    t_warped_px       warped_q[$];
    logic [PIX_W-1:0] pix_store [STORE_DEPTH];
    bit               taken [STORE_DEPTH];
    logic [DIV_W-1:0] divisor_q;
    logic [ROW_W-1:0] width_q;
    int               mismatches = 0;

    function automatic t_warped_px warp_pixel(input logic [COL_W-1:0] col,
                                              input logic [DISP_W-1:0] disp);
        int               step;
        int               src;
        logic [PIX_W-1:0] px;
        t_warped_px       w;
        step = (divisor_q == '0) ? 1 : int'(divisor_q);
        src = int'(disp) / step + int'(col) + 1;
        w.column  = col;
        w.shifted = 1'b0;
        if (src < int'(width_q) && src < STORE_DEPTH) begin
            // a source pixel is handed out once; later claims get black
            px = taken[src] ? '0 : pix_store[src];
            taken[src] = 1'b1;
            w.shifted = 1'b1;
        end else begin
            px = pix_store[int'(col) % STORE_DEPTH];
        end
        {w.red, w.green, w.blue} = px;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_warped_px exp_px;
        t_warped_px new_px;
        if (!i_rst_n) begin
            foreach (taken[k]) taken[k] = 1'b0;
            divisor_q = DIVISOR_RST;
            width_q   = ROW_WIDTH_RST;
            warped_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DIVISOR:   divisor_q = i_cfg_data[DIV_W-1:0];
                    CFG_ROW_WIDTH: width_q   = i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                if (warped_q.size() == 0) begin
                    mismatches++;
                    $error("result for column %0d arrived with no pixel expected",
                           res_ch.out_column);
                end else begin
                    exp_px = warped_q.pop_front();
                    if (res_ch.out_column !== exp_px.column) begin
                        mismatches++;
                        $error("out_column: expected %0d, got %0d",
                               exp_px.column, res_ch.out_column);
                    end
                    if (res_ch.out_red !== exp_px.red) begin
                        mismatches++;
                        $error("out_red: expected %0h, got %0h", exp_px.red, res_ch.out_red);
                    end
                    if (res_ch.out_green !== exp_px.green) begin
                        mismatches++;
                        $error("out_green: expected %0h, got %0h",
                               exp_px.green, res_ch.out_green);
                    end
                    if (res_ch.out_blue !== exp_px.blue) begin
                        mismatches++;
                        $error("out_blue: expected %0h, got %0h",
                               exp_px.blue, res_ch.out_blue);
                    end
                    if (res_ch.shifted !== exp_px.shifted) begin
                        mismatches++;
                        $error("shifted: expected %0b, got %0b",
                               exp_px.shifted, res_ch.shifted);
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                if (item_ch.mode == MODE_LOAD) begin
                    pix_store[int'(item_ch.column) % STORE_DEPTH] =
                        {item_ch.red, item_ch.green, item_ch.blue};
                    taken[int'(item_ch.column) % STORE_DEPTH] = 1'b0;
                end else begin
                    new_px = warp_pixel(item_ch.column, item_ch.disparity);
                    if (new_px.shifted) o_shifted_count++;
                    warped_q.push_back(new_px);
                end
            end
        end
        o_pending    = warped_q.size();
        // expectations still waiting at the end count as failures
        o_fail_count = mismatches + warped_q.size();
    end

endmodule

@@ tb/sv/disparity_row_view_warp_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives loads, process transactions and register settings into the view warp.
module disparity_row_view_warp_tb;
    import drvw_pkg::*;

    localparam int STORE_DEPTH   = MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 25;
    localparam int NUM_PHASES    = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    drvw_item_if   item_ch ();
    drvw_result_if res_ch ();

    int               pending;
    int               fail_count;
    int               shifted_count;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               load_count     = 0;
    int               proc_count     = 0;
    int               setting_count  = 0;
    int               items_sent     = 0;
    int               cycles         = 0;
    bit               loaded [STORE_DEPTH];
    logic [DIV_W-1:0] divisor_cfg;
    logic [ROW_W-1:0] width_cfg;

    disparity_row_view_warp u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (res_ch)
    );

    drvw_warp_checker #(.STORE_DEPTH(STORE_DEPTH)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .item_ch         (item_ch),
        .res_ch          (res_ch),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_shifted_count (shifted_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("disparity_row_view_warp: mismatch");
            $finish;
        end
    end

    // Hold each transaction until the block takes it; valid is left high, dropped only by sender gaps or wait_results.
    task automatic push_item(input logic mode, input int col, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                             input logic [DISP_W-1:0] disp);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= mode;
        item_ch.column    <= COL_W'(col);
        item_ch.red       <= r;
        item_ch.green     <= g;
        item_ch.blue      <= b;
        item_ch.disparity <= disp;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
        if (mode == MODE_LOAD) begin
            loaded[col % STORE_DEPTH] = 1'b1;
            load_count++;
        end else begin
            proc_count++;
        end
    endtask

    // Drop valid, wait for every pending pixel, then let trailing loads settle.
    task automatic wait_results();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] div_data,
                                input logic [CFG_DATA_W-1:0] width_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIVISOR;
        i_cfg_data <= div_data;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ROW_WIDTH;
        i_cfg_data <= width_data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        divisor_cfg = div_data[DIV_W-1:0];
        width_cfg   = width_data[ROW_W-1:0];
        setting_count++;
    endtask

    // True when processing this column would only touch store entries already loaded.
    function automatic bit reads_loaded(input int col, input int disp);
        int step;
        int src;
        step = (divisor_cfg == '0) ? 1 : int'(divisor_cfg);
        src = disp / step + col + 1;
        if (src < int'(width_cfg) && src < STORE_DEPTH) return loaded[src];
        return loaded[col % STORE_DEPTH];
    endfunction

    function automatic int pick_disp(input int col);
        int d;
        int t;
        for (t = 0; t < 8; t++) begin
            case ($urandom_range(9))
                0, 1, 2: d = 0;
                3:       d = 255;
                default: d = $urandom_range(255);
            endcase
            if (reads_loaded(col, d)) return d;
        end
        return -1;
    endfunction

    // Load a run of pixels, then process those of the same columns that read loaded entries, in ascending order.
    task automatic warp_row();
        int n;
        int lim;
        int base;
        int d;
        int k;
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 16);
        lim = (width_cfg > 0 && width_cfg < STORE_DEPTH) ? int'(width_cfg) : STORE_DEPTH;
        if ($urandom_range(1) == 1 && lim > n) base = $urandom_range(lim - n, 0);
        else base = $urandom_range(STORE_DEPTH - n, 0);
        for (k = 0; k < n; k++)
            push_item(MODE_LOAD, base + k, $urandom, $urandom, $urandom, $urandom);
        for (k = 0; k < n; k++) begin
            d = pick_disp(base + k);
            if (d >= 0)
                push_item(MODE_PROC, base + k, $urandom, $urandom, $urandom, DISP_W'(d));
        end
    endtask

    task automatic stray_item();
        int col;
        int d;
        col = $urandom_range(STORE_DEPTH - 1);
        d = ($urandom_range(1) == 1) ? pick_disp(col) : -1;
        if (d >= 0) push_item(MODE_PROC, col, $urandom, $urandom, $urandom, DISP_W'(d));
        else push_item(MODE_LOAD, col, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic run_phase(input int p);
        t_idle_mode mode;
        int         start;
        bit         held;
        mode  = t_idle_mode'(p % 4);
        start = items_sent;
        held  = 1'b0;
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default:   begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
        while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(99) < 15) stray_item();
            else warp_row();
            // in phase 2, one mid-phase hold-off until the result stream is empty
            if (p == 2 && !held && items_sent - start >= PHASE_ITEMS / 2) begin
                wait_results();
                held = 1'b1;
            end
        end
    endtask

    initial begin
        int p;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_DIVISOR;
        i_cfg_data        <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.mode      <= MODE_LOAD;
        item_ch.column    <= '0;
        item_ch.red       <= '0;
        item_ch.green     <= '0;
        item_ch.blue      <= '0;
        item_ch.disparity <= '0;
        divisor_cfg = DIVISOR_RST;
        width_cfg   = ROW_WIDTH_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: divisor 10, row width 640
        push_item(MODE_LOAD, 0,    8'hFF, 8'h00, 8'hFF, 8'h00);
        push_item(MODE_LOAD, 1,    8'h00, 8'hFF, 8'h00, 8'hFF);
        push_item(MODE_LOAD, 2,    8'h12, 8'h34, 8'h56, 8'h00);
        push_item(MODE_LOAD, 3,    8'hAB, 8'hCD, 8'hEF, 8'h00);
        push_item(MODE_LOAD, 26,   8'hA5, 8'h5A, 8'hC3, 8'h00);
        push_item(MODE_LOAD, 638,  8'h80, 8'h80, 8'h80, 8'h00);
        push_item(MODE_LOAD, 639,  8'h01, 8'h02, 8'h03, 8'h00);
        push_item(MODE_LOAD, 2047, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_item(MODE_PROC, 0,    8'h00, 8'h00, 8'h00, 8'd0);
        push_item(MODE_PROC, 0,    8'hFF, 8'hFF, 8'hFF, 8'd15);
        // source already handed out: expect black
        push_item(MODE_PROC, 1,    8'h00, 8'h00, 8'h00, 8'd5);
        push_item(MODE_PROC, 0,    8'h00, 8'h00, 8'h00, 8'd255);
        push_item(MODE_PROC, 638,  8'h00, 8'h00, 8'h00, 8'd0);
        // source at the row width: original pixel
        push_item(MODE_PROC, 639,  8'h00, 8'h00, 8'h00, 8'd0);
        push_item(MODE_PROC, 638,  8'h00, 8'h00, 8'h00, 8'd10);
        push_item(MODE_PROC, 2047, 8'h00, 8'h00, 8'h00, 8'd255);
        // reload clears the taken mark
        push_item(MODE_LOAD, 1,    8'h55, 8'hAA, 8'h55, 8'h00);
        push_item(MODE_PROC, 0,    8'h00, 8'h00, 8'h00, 8'd9);
        wait_results();

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: program_regs(12'h001, 12'd2048);
                1: program_regs(12'hFFF, 12'd4095);
                2: program_regs(12'hF00, 12'd64);
                3: program_regs(12'h003, 12'd0);
                4: program_regs(12'h001, 12'd1);
                5: program_regs(12'hA02, 12'd2047);
                default: program_regs(CFG_DATA_W'($urandom),
                                      ($urandom_range(1) == 1) ? CFG_DATA_W'($urandom_range(1, 100))
                                                               : CFG_DATA_W'($urandom));
            endcase
            run_phase(p);
            wait_results();
        end

        $display("covered %0d loads and %0d process transactions, %0d of them shifted",
                 load_count, proc_count, shifted_count);
        $display("over %0d register settings with sender gaps and receiver stalls",
                 setting_count + 1);
        if (fail_count == 0) begin
            $display("disparity_row_view_warp: match");
        end else begin
            $display("disparity_row_view_warp: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/drvw_pkg.sv
src/drvw_item_if.sv
src/drvw_result_if.sv
src/disparity_row_view_warp.sv
tb/sv/drvw_warp_checker.sv
tb/sv/disparity_row_view_warp_tb.sv
